// ===== rtl/core/mc2p_pkg.sv =====
package mc2p_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int DENS_BITS = WORD_BITS - 1;
   localparam int SQ_BITS   = 2 * WORD_BITS;
   localparam int QUO_BITS  = 40;
   localparam int DIVD_BITS = SQ_BITS;
   localparam int DIVR_BITS = WORD_BITS;
   localparam int HEAD_BITS = DIVD_BITS - QUO_BITS;
   localparam int ENG_BITS  = QUO_BITS + 1;
   localparam int IE_BITS   = ENG_BITS + 2;
   localparam int EM_SHIFT  = FRAC_BITS + 1;
   localparam int LANES     = 5;

   localparam int LANE_VX = 0;
   localparam int LANE_VY = 1;
   localparam int LANE_VZ = 2;
   localparam int LANE_CC = 3;
   localparam int LANE_EK = 4;

   localparam logic [ENG_BITS-1:0] ENG_CLAMP = {1'b1, {QUO_BITS{1'b0}}};
   localparam logic signed [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   typedef struct packed {
      logic [DIVR_BITS-1:0] rem;
      logic [QUO_BITS-1:0]  word;
      logic [DIVR_BITS-1:0] div;
      logic                 ovf;
   } lane_type;

   typedef struct packed {
      logic [DENS_BITS-1:0]        density;
      logic [LANE_CC:0]            neg;
      logic signed [WORD_BITS-1:0] et;
      logic [ENG_BITS-1:0]         em;
      logic signed [WORD_BITS-1:0] bx;
      logic signed [WORD_BITS-1:0] by;
      logic signed [WORD_BITS-1:0] bz;
      logic                        zero;
   } side_type;

   function automatic lane_type make_lane(logic [DIVD_BITS-1:0] n,
                                          logic [DIVR_BITS-1:0] d);
      lane_type r;
      r.rem  = {{(DIVR_BITS-HEAD_BITS){1'b0}}, n[DIVD_BITS-1:QUO_BITS]};
      r.word = n[QUO_BITS-1:0];
      r.div  = d;
      r.ovf  = ({{(DIVR_BITS-HEAD_BITS){1'b0}}, n[DIVD_BITS-1:QUO_BITS]} >= d);
      return r;
   endfunction

   function automatic lane_type div_step(lane_type l);
      logic [DIVR_BITS:0] t;
      lane_type           r;
      r = l;
      t = {l.rem, l.word[QUO_BITS-1]};
      if (t >= {1'b0, l.div}) begin
         t = t - {1'b0, l.div};
         r.word = {l.word[QUO_BITS-2:0], 1'b1};
      end else begin
         r.word = {l.word[QUO_BITS-2:0], 1'b0};
      end
      r.rem = t[DIVR_BITS-1:0];
      return r;
   endfunction

endpackage

// ===== rtl/core/mc2p_front.sv =====
module mc2p_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [mc2p_pkg::DENS_BITS-1:0]       density,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] momentum_x,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] momentum_y,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] momentum_z,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] total_energy,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] scalar_mass,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] field_x_lower,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] field_x_upper,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] field_y_lower,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] field_y_upper,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] field_z_lower,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] field_z_upper,
   output logic                                 out_valid,
   output mc2p_pkg::side_type                   out_side,
   output mc2p_pkg::lane_type                   out_lane [mc2p_pkg::LANES]
);

   localparam int W = mc2p_pkg::WORD_BITS;

   typedef struct packed {
      logic [mc2p_pkg::DENS_BITS-1:0] d;
      logic [W-1:0]                   amx;
      logic [W-1:0]                   amy;
      logic [W-1:0]                   amz;
      logic [W-1:0]                   asc;
      logic [mc2p_pkg::LANE_CC:0]     neg;
      logic signed [W-1:0]            et;
      logic signed [W-1:0]            bx;
      logic signed [W-1:0]            by;
      logic signed [W-1:0]            bz;
      logic                           zero;
   } s1_type;

   typedef struct packed {
      s1_type                         a;
      logic [mc2p_pkg::SQ_BITS-1:0]   qmx;
      logic [mc2p_pkg::SQ_BITS-1:0]   qmy;
      logic [mc2p_pkg::SQ_BITS-1:0]   qmz;
      logic [mc2p_pkg::SQ_BITS-1:0]   qbx;
      logic [mc2p_pkg::SQ_BITS-1:0]   qby;
      logic [mc2p_pkg::SQ_BITS-1:0]   qbz;
   } s2_type;

   function automatic logic [W-1:0] mag(logic signed [W-1:0] x);
      return x[W-1] ? (~x + 1'b1) : x;
   endfunction

   function automatic logic signed [W-1:0] centre(logic signed [W-1:0] lo,
                                                  logic signed [W-1:0] hi);
      logic [W:0] s;
      s = {lo[W-1], lo} + {hi[W-1], hi};
      return s[W:1];
   endfunction

   logic   s1_valid_ff, s1_valid_in;
   s1_type s1_ff, s1_in;
   logic   s2_valid_ff, s2_valid_in;
   s2_type s2_ff, s2_in;
   logic   s3_valid_ff, s3_valid_in;
   mc2p_pkg::side_type s3_side_ff, s3_side_in;
   mc2p_pkg::lane_type s3_lane_ff [mc2p_pkg::LANES];
   mc2p_pkg::lane_type s3_lane_in [mc2p_pkg::LANES];

   logic signed [mc2p_pkg::SQ_BITS-1:0] sqbx, sqby, sqbz;
   logic [mc2p_pkg::SQ_BITS-1:0]        msum, bsum;
   logic [mc2p_pkg::SQ_BITS-1:0]        emraw;
   logic [mc2p_pkg::DIVR_BITS-1:0]      dv, d2;

   always_comb begin
      s1_valid_in = in_valid;
      s1_in.d     = density;
      s1_in.amx   = mag(momentum_x);
      s1_in.amy   = mag(momentum_y);
      s1_in.amz   = mag(momentum_z);
      s1_in.asc   = mag(scalar_mass);
      s1_in.neg   = {scalar_mass[W-1], momentum_z[W-1], momentum_y[W-1], momentum_x[W-1]};
      s1_in.et    = total_energy;
      s1_in.bx    = centre(field_x_lower, field_x_upper);
      s1_in.by    = centre(field_y_lower, field_y_upper);
      s1_in.bz    = centre(field_z_lower, field_z_upper);
      s1_in.zero  = (density == '0);
   end

   assign sqbx = s1_ff.bx * s1_ff.bx;
   assign sqby = s1_ff.by * s1_ff.by;
   assign sqbz = s1_ff.bz * s1_ff.bz;

   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_in.a     = s1_ff;
      s2_in.qmx   = s1_ff.amx * s1_ff.amx;
      s2_in.qmy   = s1_ff.amy * s1_ff.amy;
      s2_in.qmz   = s1_ff.amz * s1_ff.amz;
      s2_in.qbx   = sqbx;
      s2_in.qby   = sqby;
      s2_in.qbz   = sqbz;
   end

   assign msum  = s2_ff.qmx + s2_ff.qmy + s2_ff.qmz;
   assign bsum  = s2_ff.qbx + s2_ff.qby + s2_ff.qbz;
   assign emraw = bsum >> mc2p_pkg::EM_SHIFT;
   assign dv    = {1'b0, s2_ff.a.d};
   assign d2    = {s2_ff.a.d, 1'b0};

   always_comb begin
      s3_valid_in        = s2_valid_ff;
      s3_side_in.density = s2_ff.a.d;
      s3_side_in.neg     = s2_ff.a.neg;
      s3_side_in.et      = s2_ff.a.et;
      s3_side_in.em      = (emraw > {{(mc2p_pkg::SQ_BITS-mc2p_pkg::ENG_BITS){1'b0}},
                                     mc2p_pkg::ENG_CLAMP})
                           ? mc2p_pkg::ENG_CLAMP : emraw[mc2p_pkg::ENG_BITS-1:0];
      s3_side_in.bx      = s2_ff.a.bx;
      s3_side_in.by      = s2_ff.a.by;
      s3_side_in.bz      = s2_ff.a.bz;
      s3_side_in.zero    = s2_ff.a.zero;
      s3_lane_in[mc2p_pkg::LANE_VX] = mc2p_pkg::make_lane(
         {{(W-mc2p_pkg::FRAC_BITS){1'b0}}, s2_ff.a.amx, {mc2p_pkg::FRAC_BITS{1'b0}}}, dv);
      s3_lane_in[mc2p_pkg::LANE_VY] = mc2p_pkg::make_lane(
         {{(W-mc2p_pkg::FRAC_BITS){1'b0}}, s2_ff.a.amy, {mc2p_pkg::FRAC_BITS{1'b0}}}, dv);
      s3_lane_in[mc2p_pkg::LANE_VZ] = mc2p_pkg::make_lane(
         {{(W-mc2p_pkg::FRAC_BITS){1'b0}}, s2_ff.a.amz, {mc2p_pkg::FRAC_BITS{1'b0}}}, dv);
      s3_lane_in[mc2p_pkg::LANE_CC] = mc2p_pkg::make_lane(
         {{(W-mc2p_pkg::FRAC_BITS){1'b0}}, s2_ff.a.asc, {mc2p_pkg::FRAC_BITS{1'b0}}}, dv);
      s3_lane_in[mc2p_pkg::LANE_EK] = mc2p_pkg::make_lane(msum, d2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff      <= s1_in;
         s2_ff      <= s2_in;
         s3_side_ff <= s3_side_in;
         s3_lane_ff <= s3_lane_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_side  = s3_side_ff;
   assign out_lane  = s3_lane_ff;

endmodule

// ===== rtl/core/mc2p_divider.sv =====
module mc2p_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  mc2p_pkg::side_type in_side,
   input  mc2p_pkg::lane_type in_lane [mc2p_pkg::LANES],
   output logic               out_valid,
   output mc2p_pkg::side_type out_side,
   output mc2p_pkg::lane_type out_lane [mc2p_pkg::LANES]
);

   localparam int N = mc2p_pkg::QUO_BITS;

   logic               valid_ff [N];
   mc2p_pkg::side_type side_ff  [N];
   mc2p_pkg::lane_type lane_ff  [N][mc2p_pkg::LANES];

   for (genvar s = 0; s < N; s++) begin : g_stage
      logic               valid_in;
      mc2p_pkg::side_type side_in;
      mc2p_pkg::lane_type lane_in [mc2p_pkg::LANES];

      always_comb begin
         if (s == 0) begin
            valid_in = in_valid;
            side_in  = in_side;
            for (int k = 0; k < mc2p_pkg::LANES; k++) begin
               lane_in[k] = mc2p_pkg::div_step(in_lane[k]);
            end
         end else begin
            valid_in = valid_ff[(s == 0) ? 0 : s-1];
            side_in  = side_ff[(s == 0) ? 0 : s-1];
            for (int k = 0; k < mc2p_pkg::LANES; k++) begin
               lane_in[k] = mc2p_pkg::div_step(lane_ff[(s == 0) ? 0 : s-1][k]);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[s] <= side_in;
            lane_ff[s] <= lane_in;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_side  = side_ff[N-1];
   assign out_lane  = lane_ff[N-1];

endmodule

// ===== rtl/core/mc2p_back.sv =====
module mc2p_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  mc2p_pkg::side_type                    in_side,
   input  mc2p_pkg::lane_type                    in_lane [mc2p_pkg::LANES],
   output logic                                  out_valid,
   output logic [mc2p_pkg::DENS_BITS-1:0]        density_out,
   output logic signed [mc2p_pkg::WORD_BITS-1:0] velocity_x,
   output logic signed [mc2p_pkg::WORD_BITS-1:0] velocity_y,
   output logic signed [mc2p_pkg::WORD_BITS-1:0] velocity_z,
   output logic signed [mc2p_pkg::WORD_BITS-1:0] internal_energy,
   output logic signed [mc2p_pkg::WORD_BITS-1:0] scalar_concentration,
   output logic signed [mc2p_pkg::WORD_BITS-1:0] centred_field_x,
   output logic signed [mc2p_pkg::WORD_BITS-1:0] centred_field_y,
   output logic signed [mc2p_pkg::WORD_BITS-1:0] centred_field_z,
   output logic                                  saturated,
   output logic                                  zero_density
);

   localparam int W  = mc2p_pkg::WORD_BITS;
   localparam int Q  = mc2p_pkg::QUO_BITS;
   localparam int IE = mc2p_pkg::IE_BITS;

   typedef struct packed {
      logic [mc2p_pkg::DENS_BITS-1:0] density;
      logic signed [W-1:0]            vx;
      logic signed [W-1:0]            vy;
      logic signed [W-1:0]            vz;
      logic signed [W-1:0]            ie;
      logic signed [W-1:0]            cc;
      logic signed [W-1:0]            bx;
      logic signed [W-1:0]            by;
      logic signed [W-1:0]            bz;
      logic                           sat;
      logic                           zero;
   } rsp_type;

   typedef struct packed {
      logic signed [W-1:0] value;
      logic                sat;
   } quot_type;

   function automatic quot_type fix_quot(mc2p_pkg::lane_type l, logic neg);
      quot_type            r;
      logic [Q-1:0]        limit;
      limit = neg ? {{(Q-W){1'b0}}, 1'b1, {(W-1){1'b0}}}
                  : {{(Q-W+1){1'b0}}, {(W-1){1'b1}}};
      r.sat = l.ovf || (l.word > limit);
      if (r.sat) begin
         r.value = neg ? mc2p_pkg::SMIN : mc2p_pkg::SMAX;
      end else begin
         r.value = neg ? (~l.word[W-1:0] + 1'b1) : l.word[W-1:0];
      end
      return r;
   endfunction

   quot_type                      qx, qy, qz, qc;
   logic [mc2p_pkg::ENG_BITS-1:0] ek;
   logic signed [IE-1:0]          iw;
   logic                          ie_sat;
   logic signed [W-1:0]           ie_val;
   logic                          valid_ff, valid_in;
   rsp_type                       rsp_ff, rsp_in;

   assign qx = fix_quot(in_lane[mc2p_pkg::LANE_VX], in_side.neg[mc2p_pkg::LANE_VX]);
   assign qy = fix_quot(in_lane[mc2p_pkg::LANE_VY], in_side.neg[mc2p_pkg::LANE_VY]);
   assign qz = fix_quot(in_lane[mc2p_pkg::LANE_VZ], in_side.neg[mc2p_pkg::LANE_VZ]);
   assign qc = fix_quot(in_lane[mc2p_pkg::LANE_CC], in_side.neg[mc2p_pkg::LANE_CC]);
   assign ek = in_lane[mc2p_pkg::LANE_EK].ovf ? mc2p_pkg::ENG_CLAMP
             : {1'b0, in_lane[mc2p_pkg::LANE_EK].word};
   assign iw = {{(IE-W){in_side.et[W-1]}}, in_side.et}
             - $signed({2'b00, ek}) - $signed({2'b00, in_side.em});

   always_comb begin
      if (iw > $signed({{(IE-W){1'b0}}, mc2p_pkg::SMAX})) begin
         ie_sat = 1'b1;
         ie_val = mc2p_pkg::SMAX;
      end else if (iw < $signed({{(IE-W){1'b1}}, mc2p_pkg::SMIN})) begin
         ie_sat = 1'b1;
         ie_val = mc2p_pkg::SMIN;
      end else begin
         ie_sat = 1'b0;
         ie_val = iw[W-1:0];
      end
   end

   always_comb begin
      valid_in       = in_valid;
      rsp_in.density = in_side.density;
      rsp_in.bx      = in_side.bx;
      rsp_in.by      = in_side.by;
      rsp_in.bz      = in_side.bz;
      rsp_in.zero    = in_side.zero;
      if (in_side.zero) begin
         rsp_in.vx  = '0;
         rsp_in.vy  = '0;
         rsp_in.vz  = '0;
         rsp_in.ie  = '0;
         rsp_in.cc  = '0;
         rsp_in.sat = 1'b0;
      end else begin
         rsp_in.vx  = qx.value;
         rsp_in.vy  = qy.value;
         rsp_in.vz  = qz.value;
         rsp_in.ie  = ie_val;
         rsp_in.cc  = qc.value;
         rsp_in.sat = qx.sat | qy.sat | qz.sat | qc.sat | ie_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid            = valid_ff;
   assign density_out          = rsp_ff.density;
   assign velocity_x           = rsp_ff.vx;
   assign velocity_y           = rsp_ff.vy;
   assign velocity_z           = rsp_ff.vz;
   assign internal_energy      = rsp_ff.ie;
   assign scalar_concentration = rsp_ff.cc;
   assign centred_field_x      = rsp_ff.bx;
   assign centred_field_y      = rsp_ff.by;
   assign centred_field_z      = rsp_ff.bz;
   assign saturated            = rsp_ff.sat;
   assign zero_density         = rsp_ff.zero;

endmodule

// ===== rtl/core/mhd_conserved_to_primitive_unit.sv =====
// A request transfer passes through three operand, square and sum stages, forty
// restoring divider stages and one output stage on the way to its response.
// Throughput: one cell per cycle; the whole pipeline holds while a response waits.
// Reset clears the valid bits of every stage; data registers are not reset.
module mhd_conserved_to_primitive_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [mc2p_pkg::DENS_BITS-1:0]        req_density,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_momentum_x,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_momentum_y,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_momentum_z,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_total_energy,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_scalar_mass,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_field_x_lower,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_field_x_upper,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_field_y_lower,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_field_y_upper,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_field_z_lower,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_field_z_upper,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mc2p_pkg::DENS_BITS-1:0]        rsp_density_out,
   output logic signed [mc2p_pkg::WORD_BITS-1:0] rsp_velocity_x,
   output logic signed [mc2p_pkg::WORD_BITS-1:0] rsp_velocity_y,
   output logic signed [mc2p_pkg::WORD_BITS-1:0] rsp_velocity_z,
   output logic signed [mc2p_pkg::WORD_BITS-1:0] rsp_internal_energy,
   output logic signed [mc2p_pkg::WORD_BITS-1:0] rsp_scalar_concentration,
   output logic signed [mc2p_pkg::WORD_BITS-1:0] rsp_centred_field_x,
   output logic signed [mc2p_pkg::WORD_BITS-1:0] rsp_centred_field_y,
   output logic signed [mc2p_pkg::WORD_BITS-1:0] rsp_centred_field_z,
   output logic                                  rsp_saturated,
   output logic                                  rsp_zero_density
);

   logic               en;
   logic               f_valid, d_valid;
   mc2p_pkg::side_type f_side, d_side;
   mc2p_pkg::lane_type f_lane [mc2p_pkg::LANES];
   mc2p_pkg::lane_type d_lane [mc2p_pkg::LANES];

   // advance unless a response is held
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   mc2p_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .density      (req_density),
      .momentum_x   (req_momentum_x),
      .momentum_y   (req_momentum_y),
      .momentum_z   (req_momentum_z),
      .total_energy (req_total_energy),
      .scalar_mass  (req_scalar_mass),
      .field_x_lower(req_field_x_lower),
      .field_x_upper(req_field_x_upper),
      .field_y_lower(req_field_y_lower),
      .field_y_upper(req_field_y_upper),
      .field_z_lower(req_field_z_lower),
      .field_z_upper(req_field_z_upper),
      .out_valid    (f_valid),
      .out_side     (f_side),
      .out_lane     (f_lane)
   );

   mc2p_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (f_valid),
      .in_side  (f_side),
      .in_lane  (f_lane),
      .out_valid(d_valid),
      .out_side (d_side),
      .out_lane (d_lane)
   );

   mc2p_back u_back (
      .clock               (clock),
      .reset               (reset),
      .en                  (en),
      .in_valid            (d_valid),
      .in_side             (d_side),
      .in_lane             (d_lane),
      .out_valid           (rsp_valid),
      .density_out         (rsp_density_out),
      .velocity_x          (rsp_velocity_x),
      .velocity_y          (rsp_velocity_y),
      .velocity_z          (rsp_velocity_z),
      .internal_energy     (rsp_internal_energy),
      .scalar_concentration(rsp_scalar_concentration),
      .centred_field_x     (rsp_centred_field_x),
      .centred_field_y     (rsp_centred_field_y),
      .centred_field_z     (rsp_centred_field_z),
      .saturated           (rsp_saturated),
      .zero_density        (rsp_zero_density)
   );

endmodule

// ===== test/mhd_conserved_to_primitive_checker.sv =====
module mhd_conserved_to_primitive_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic [mc2p_pkg::DENS_BITS-1:0]        req_density,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_momentum_x,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_momentum_y,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_momentum_z,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_total_energy,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_scalar_mass,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_field_x_lower,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_field_x_upper,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_field_y_lower,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_field_y_upper,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_field_z_lower,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] req_field_z_upper,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [mc2p_pkg::DENS_BITS-1:0]        rsp_density_out,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] rsp_velocity_x,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] rsp_velocity_y,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] rsp_velocity_z,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] rsp_internal_energy,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] rsp_scalar_concentration,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] rsp_centred_field_x,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] rsp_centred_field_y,
   input  logic signed [mc2p_pkg::WORD_BITS-1:0] rsp_centred_field_z,
   input  logic                                  rsp_saturated,
   input  logic                                  rsp_zero_density,
   output int                                    fail_count,
   output int                                    cells_in_flight
);
   import mc2p_pkg::*;

   typedef struct {
      logic [DENS_BITS-1:0] density;
      logic [WORD_BITS-1:0] vx, vy, vz, ie, cc, bx, by, bz;
      logic                 sat, zero;
   } primitive_cell_type;

   primitive_cell_type primitives_due[$];

   localparam longint WMAX = longint'(SMAX);
   localparam longint WMIN = longint'(SMIN);
   localparam longint ENERGY_CAP = longint'(1) << 40;

   function automatic longint clamp_word(longint v, inout logic sat);
      if (v > WMAX) begin
         sat = 1'b1;
         return WMAX;
      end
      if (v < WMIN) begin
         sat = 1'b1;
         return WMIN;
      end
      return v;
   endfunction

   function automatic longint scaled_quotient(longint num, longint d, inout logic sat);
      return clamp_word((num * (longint'(1) << FRAC_BITS)) / d, sat);
   endfunction

   function automatic primitive_cell_type convert_cell();
      primitive_cell_type p;
      longint d, mx, my, mz, bx, by, bz, ie;
      logic [63:0] ek, em, sum_sq, twice_d;
      logic sat;
      d  = longint'(req_density);
      mx = longint'(req_momentum_x);
      my = longint'(req_momentum_y);
      mz = longint'(req_momentum_z);
      bx = (longint'(req_field_x_lower) + longint'(req_field_x_upper)) >>> 1;
      by = (longint'(req_field_y_lower) + longint'(req_field_y_upper)) >>> 1;
      bz = (longint'(req_field_z_lower) + longint'(req_field_z_upper)) >>> 1;
      sat = 1'b0;
      p.density = req_density;
      p.zero = (d == 0);
      p.bx = bx[WORD_BITS-1:0];
      p.by = by[WORD_BITS-1:0];
      p.bz = bz[WORD_BITS-1:0];
      p.vx = '0;
      p.vy = '0;
      p.vz = '0;
      p.cc = '0;
      p.ie = '0;
      if (!p.zero) begin
         p.vx = WORD_BITS'(scaled_quotient(mx, d, sat));
         p.vy = WORD_BITS'(scaled_quotient(my, d, sat));
         p.vz = WORD_BITS'(scaled_quotient(mz, d, sat));
         p.cc = WORD_BITS'(scaled_quotient(longint'(req_scalar_mass), d, sat));
         sum_sq = 64'(mx * mx) + 64'(my * my) + 64'(mz * mz);
         twice_d = 64'(d) << 1;
         ek = sum_sq / twice_d;
         if (ek > 64'(ENERGY_CAP)) ek = 64'(ENERGY_CAP);
         em = (64'(bx * bx) + 64'(by * by) + 64'(bz * bz)) >> (FRAC_BITS + 1);
         if (em > 64'(ENERGY_CAP)) em = 64'(ENERGY_CAP);
         ie = clamp_word(longint'(req_total_energy) - longint'(ek) - longint'(em), sat);
         p.ie = ie[WORD_BITS-1:0];
      end
      p.sat = sat;
      return p;
   endfunction

   task automatic compare_field(string name, logic [WORD_BITS-1:0] want,
                                logic [WORD_BITS-1:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      primitive_cell_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (primitives_due.size() == 0) begin
            $error("response transfer with no cell outstanding");
            fail_count++;
         end else begin
            e = primitives_due.pop_front();
            compare_field("density_out", 32'(e.density), 32'(rsp_density_out));
            compare_field("velocity_x", e.vx, rsp_velocity_x);
            compare_field("velocity_y", e.vy, rsp_velocity_y);
            compare_field("velocity_z", e.vz, rsp_velocity_z);
            compare_field("internal_energy", e.ie, rsp_internal_energy);
            compare_field("scalar_concentration", e.cc, rsp_scalar_concentration);
            compare_field("centred_field_x", e.bx, rsp_centred_field_x);
            compare_field("centred_field_y", e.by, rsp_centred_field_y);
            compare_field("centred_field_z", e.bz, rsp_centred_field_z);
            compare_field("saturated", 32'(e.sat), 32'(rsp_saturated));
            compare_field("zero_density", 32'(e.zero), 32'(rsp_zero_density));
         end
      end
      if (!reset && req_valid && !req_stall) primitives_due.push_back(convert_cell());
      cells_in_flight = primitives_due.size();
   end

endmodule

// ===== test/tb_mhd_conserved_to_primitive_unit.sv =====
module tb_mhd_conserved_to_primitive_unit;
   import mc2p_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [DENS_BITS-1:0] req_density = '0;
   logic signed [WORD_BITS-1:0] req_momentum_x = '0, req_momentum_y = '0, req_momentum_z = '0;
   logic signed [WORD_BITS-1:0] req_total_energy = '0, req_scalar_mass = '0;
   logic signed [WORD_BITS-1:0] req_field_x_lower = '0, req_field_x_upper = '0;
   logic signed [WORD_BITS-1:0] req_field_y_lower = '0, req_field_y_upper = '0;
   logic signed [WORD_BITS-1:0] req_field_z_lower = '0, req_field_z_upper = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [DENS_BITS-1:0] rsp_density_out;
   logic signed [WORD_BITS-1:0] rsp_velocity_x, rsp_velocity_y, rsp_velocity_z;
   logic signed [WORD_BITS-1:0] rsp_internal_energy, rsp_scalar_concentration;
   logic signed [WORD_BITS-1:0] rsp_centred_field_x, rsp_centred_field_y, rsp_centred_field_z;
   logic rsp_saturated, rsp_zero_density;
   int fail_count, cells_in_flight;
   int quiet_cycles = 0;
   logic long_holdoff = 1'b0;
   logic steady_phase = 1'b0;

   always #6 clock = ~clock;

   mhd_conserved_to_primitive_unit i_dut (.*);
   mhd_conserved_to_primitive_checker i_checker (.*);

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [WORD_BITS-1:0] random_word();
      case ($urandom_range(0, 9))
         0: return SMAX;
         1: return SMIN;
         2: return 32'(signed'($urandom_range(0, 4)) - 2);
         3, 4, 5: return 32'(signed'($urandom_range(0, 1 << 21)) - (1 << 20));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DENS_BITS-1:0] random_density();
      case ($urandom_range(0, 19))
         0: return '0;
         1, 2: return DENS_BITS'($urandom_range(1, 255));
         3, 4, 5, 6, 7, 8: return DENS_BITS'($urandom_range(1, 1 << 20));
         9: return {DENS_BITS{1'b1}};
         default: return DENS_BITS'($urandom);
      endcase
   endfunction

   task automatic send_cell(logic [DENS_BITS-1:0] d, logic [WORD_BITS-1:0] w [11]);
      @(negedge clock);
      req_density = d;
      {req_momentum_x, req_momentum_y, req_momentum_z} = {w[0], w[1], w[2]};
      {req_total_energy, req_scalar_mass} = {w[3], w[4]};
      {req_field_x_lower, req_field_x_upper} = {w[5], w[6]};
      {req_field_y_lower, req_field_y_upper} = {w[7], w[8]};
      {req_field_z_lower, req_field_z_upper} = {w[9], w[10]};
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause_sender(int n);
      if (n > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      pause_sender(1);
      while (cells_in_flight != 0) @(posedge clock);
   endtask

   task automatic send_uniform(logic [DENS_BITS-1:0] d, logic [WORD_BITS-1:0] v);
      logic [WORD_BITS-1:0] w [11];
      foreach (w[i]) w[i] = v;
      send_cell(d, w);
   endtask

   task automatic send_random_cell();
      logic [WORD_BITS-1:0] w [11];
      foreach (w[i]) w[i] = random_word();
      send_cell(random_density(), w);
   endtask

   initial begin
      logic held;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (long_holdoff && !held) begin
            held = 1'b1;
            rsp_stall = 1'b1;
            repeat (300) @(negedge clock);
         end
         if (steady_phase) rsp_stall = 1'b0;
         else if ($urandom_range(0, 99) < 4) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(10, 40)) @(negedge clock);
         end else rsp_stall = ($urandom_range(0, 99) < 25);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= 2000) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [WORD_BITS-1:0] w [11];
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_uniform('0, SMAX);
      send_uniform('0, 32'h1234_5678);
      send_uniform(1, 0);
      send_uniform(1, SMAX);
      send_uniform(1, SMIN);
      send_uniform({DENS_BITS{1'b1}}, SMAX);
      send_uniform({DENS_BITS{1'b1}}, SMIN);
      send_uniform({DENS_BITS{1'b1}}, '1);
      send_uniform(DENS_BITS'(1 << 16), 32'h0001_0000);
      send_uniform(DENS_BITS'(1 << 16), 32'hFFFF_0000);
      send_uniform(DENS_BITS'(3), 32'hFFFF_FFFD);
      foreach (w[i]) w[i] = 32'd0;
      w[3] = SMAX;
      w[5] = SMAX;
      w[6] = SMAX;
      w[7] = SMIN;
      w[8] = SMIN;
      send_cell(DENS_BITS'(1 << 16), w);
      w[5] = SMIN;
      w[6] = 32'hFFFF_FFFF;
      w[7] = 32'd1;
      w[8] = 32'hFFFF_FFFE;
      w[3] = SMIN;
      send_cell(DENS_BITS'(1 << 16), w);
      foreach (w[i]) w[i] = 32'd0;
      w[0] = SMIN;
      w[3] = 32'h0001_0000;
      send_cell(DENS_BITS'(1), w);
      w[0] = 32'h0000_8000;
      w[3] = SMAX;
      send_cell(DENS_BITS'(1 << 16), w);
      w[4] = SMIN;
      send_cell(DENS_BITS'(1 << 15), w);
      drain();

      steady_phase = 1'b1;
      repeat (150) send_random_cell();
      steady_phase = 1'b0;
      long_holdoff = 1'b1;
      repeat (200) begin
         pause_sender(gap_length());
         send_random_cell();
      end
      drain();
      repeat (1250) begin
         pause_sender(gap_length());
         send_random_cell();
      end
      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/mc2p_pkg.sv
rtl/core/mc2p_front.sv
rtl/core/mc2p_divider.sv
rtl/core/mc2p_back.sv
rtl/core/mhd_conserved_to_primitive_unit.sv
test/mhd_conserved_to_primitive_checker.sv
test/tb_mhd_conserved_to_primitive_unit.sv
